>>> rtl/queue_with_positional_insert_assert.svh
// assertion macros shared by the queue rtl
`ifndef QUEUE_WITH_POSITIONAL_INSERT_ASSERT_SVH
`define QUEUE_WITH_POSITIONAL_INSERT_ASSERT_SVH

// same-cycle implication, cleared during reset
`define QWPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, cleared during reset
`define QWPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/qwpi_pkg.sv
`timescale 1ns / 1ps

package qwpi_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W  = 16;
    localparam int POS_W = 7;
    localparam int OCC_W = 7;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // opcodes of an input beat
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_DUMP   = 2'd3;

    // status codes of a result beat
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_CLAMP = 2'd3;

    // per-cell commands
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_ROTATE = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] sel;
        logic [ID_W-1:0]  id;
    } cell_ctl_t;

endpackage

>>> rtl/qwpi_cell.sv
`timescale 1ns / 1ps

module qwpi_cell (
    input  logic                       clk,
    input  logic [qwpi_pkg::IDX_W-1:0] idx,
    input  qwpi_pkg::cell_ctl_t        ctl,
    input  logic [qwpi_pkg::ID_W-1:0]  left,
    input  logic [qwpi_pkg::ID_W-1:0]  right,
    input  logic [qwpi_pkg::ID_W-1:0]  head,
    output logic [qwpi_pkg::ID_W-1:0]  data
);
    import qwpi_pkg::*;

    logic [ID_W-1:0] data_reg;
    logic [ID_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                // cells behind the slot move one place towards the tail
                if (idx > ctl.sel)
                    data_next = left;
                else if (idx == ctl.sel)
                    data_next = ctl.id;
            end
            CELL_ROTATE:
            begin
                // towards the head; the head wraps into the slot at sel
                if (idx < ctl.sel)
                    data_next = right;
                else if (idx == ctl.sel)
                    data_next = head;
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/queue_with_positional_insert.sv
`timescale 1ns / 1ps

// channel  | ports                                        | handshake
// ---------+----------------------------------------------+---------------------------
// command  | opcode, customer_id, position                | taken when start & !busy
// result   | value, has_value, last, status, occupancy    | one-cycle beat on done
//
// append, insert and remove leave busy low; the result beat follows in the
// cycle after the command is taken, so commands may run back to back.
// a dump of n entries holds busy while it emits n entry beats and the cell
// row rotates once through the head; a dump of an empty queue leaves busy low
// and gives a single closing beat like the other commands.
// rst_n clears the count and the state; cell contents stay undefined and are
// never read before being written.
// the receiver cannot stall: every beat on done is taken at once.

module queue_with_positional_insert (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic [qwpi_pkg::ID_W-1:0]  customer_id,
    input  logic [qwpi_pkg::POS_W-1:0] position,
    output logic                       done,
    output logic [qwpi_pkg::ID_W-1:0]  value,
    output logic                       has_value,
    output logic                       last,
    output logic [1:0]                 status,
    output logic [qwpi_pkg::OCC_W-1:0] occupancy
);
    import qwpi_pkg::*;

    `include "queue_with_positional_insert_assert.svh"

    // controller states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] dump_idx_reg, dump_idx_next;

    // registered result beat
    logic             done_reg, done_next;
    logic [ID_W-1:0]  value_reg, value_next;
    logic             has_value_reg, has_value_next;
    logic             last_reg, last_next;
    logic [1:0]       status_reg, status_next;
    logic [OCC_W-1:0] occupancy_reg, occupancy_next;

    cell_ctl_t        ctl;
    logic [ID_W-1:0]  cell_q [DEPTH];

    logic             accept;
    logic             full;
    logic             empty;
    logic             clamp;
    logic [IDX_W-1:0] tail_idx;

    assign busy     = (state_reg == S_DUMP);
    assign accept   = start && !busy;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    // an insert point beyond the count goes to the tail
    assign clamp    = (CMP_W'(position) > CMP_W'(count_reg));
    // index of the last occupied cell
    assign tail_idx = IDX_W'(count_reg - CNT_W'(1));

    // the row of cells: entry k sits in cell k, head in cell 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [ID_W-1:0] left_d;
        logic [ID_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_end
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[g+1];
        end

        qwpi_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(g)),
            .ctl   (ctl),
            .left  (left_d),
            .right (right_d),
            .head  (cell_q[0]),
            .data  (cell_q[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        ctl.op         = CELL_HOLD;
        ctl.sel        = '0;
        ctl.id         = customer_id;
        done_next      = 1'b0;
        value_next     = '0;
        has_value_next = 1'b0;
        last_next      = 1'b0;
        status_next    = ST_OK;
        occupancy_next = occupancy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_APPEND, OP_INSERT:
                        begin
                            if (full)
                            begin
                                // dropped, contents untouched
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.op = CELL_INSERT;
                                if (opcode == OP_INSERT && !clamp)
                                    ctl.sel = IDX_W'(position);
                                else
                                    ctl.sel = IDX_W'(count_reg);
                                if (opcode == OP_INSERT && clamp)
                                    status_next = ST_CLAMP;
                                count_next = count_reg + CNT_W'(1);
                            end
                            done_next = 1'b1;
                            last_next = 1'b1;
                        end
                        OP_REMOVE:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // shift towards the head; the old head lands
                                // beyond the new tail and is never read
                                ctl.op     = CELL_ROTATE;
                                ctl.sel    = tail_idx;
                                count_next = count_reg - CNT_W'(1);
                            end
                            done_next = 1'b1;
                            last_next = 1'b1;
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                            begin
                                done_next = 1'b1;
                                last_next = 1'b1;
                            end
                            else
                            begin
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                    occupancy_next = OCC_W'(count_next);
                end
            end
            S_DUMP:
            begin
                // emit the head and rotate it to the tail; once every entry has
                // been emitted the row is back in its original order
                ctl.op         = CELL_ROTATE;
                ctl.sel        = tail_idx;
                done_next      = 1'b1;
                value_next     = cell_q[0];
                has_value_next = 1'b1;
                last_next      = (dump_idx_reg == tail_idx);
                occupancy_next = OCC_W'(count_reg);
                dump_idx_next  = dump_idx_reg + IDX_W'(1);
                if (dump_idx_reg == tail_idx)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            done_reg     <= done_next;
        end
    end

    // result payload, meaningful only alongside done
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        has_value_reg <= has_value_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
        occupancy_reg <= occupancy_next;
    end

    assign done      = done_reg;
    assign value     = value_reg;
    assign has_value = has_value_reg;
    assign last      = last_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    // the queue never holds more than its depth
    `QWPI_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH),
        "count above depth")
    // a dump never walks past the tail
    `QWPI_ASSERT_NOW(a_dump_idx, clk, rst_n, busy,
        (!empty) && (dump_idx_reg <= tail_idx), "dump index beyond tail")
    // every non-dump command gives exactly one closing beat next cycle
    `QWPI_ASSERT_NEXT(a_cmd_beat, clk, rst_n, accept && (opcode != OP_DUMP),
        done && last && !has_value && !busy, "missing status beat")
    // a dump of a non-empty queue always raises busy before its first entry beat
    `QWPI_ASSERT_NEXT(a_dump_beat, clk, rst_n, accept && (opcode == OP_DUMP) && !empty,
        busy && !done, "dump did not start")
    // the count never changes while a dump walks the row
    `QWPI_ASSERT_NEXT(a_dump_count, clk, rst_n, busy, $stable(count_reg),
        "count moved during dump")

endmodule
